// ===== sv/fern_pkg.sv =====
// ----------------------------------------------------------------------------
// fern_pkg
// Shared types, widths, codes and coefficient helper for the fern point
// generator.
// ----------------------------------------------------------------------------
package fern_pkg;

    // field widths
    localparam int CHOICE_W  = 7;
    localparam int THR_W     = 7;
    localparam int COORD_W   = 32;
    localparam int MAP_W     = 2;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT = 2'd2;

    // threshold reset values
    localparam logic [THR_W-1:0] STEM_THR_RST = 7'd1;
    localparam logic [THR_W-1:0] MAIN_THR_RST = 7'd80;
    localparam logic [THR_W-1:0] LEFT_THR_RST = 7'd90;

    // affine map codes
    typedef enum logic [MAP_W-1:0] {
        MAP_STEM  = 2'd0,
        MAP_MAIN  = 2'd1,
        MAP_LEFT  = 2'd2,
        MAP_RIGHT = 2'd3
    } t_map;

    // threshold register set
    typedef struct packed {
        logic [THR_W-1:0] stem;
        logic [THR_W-1:0] main;
        logic [THR_W-1:0] left;
    } t_thr;

    // hundredths to fixed point, rounded to nearest
    function automatic logic signed [63:0] qc(input int hundredths, input int frac);
        logic signed [63:0] v;
        v = (64'(hundredths) << frac) + 64'sd50;
        return v / 100;
    endfunction

endpackage

// ===== sv/fern_choice_if.sv =====
// ----------------------------------------------------------------------------
// fern_choice_if
// Valid/ready channel carrying one random choice word.
// ----------------------------------------------------------------------------
interface fern_choice_if import fern_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [CHOICE_W-1:0] choice_value;

    modport source (output valid, output choice_value, input ready);
    modport sink   (input valid, input choice_value, output ready);

endinterface

// ===== sv/fern_point_if.sv =====
// ----------------------------------------------------------------------------
// fern_point_if
// Valid/ready channel carrying one generated point word.
// ----------------------------------------------------------------------------
interface fern_point_if import fern_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y_shifted;
    logic [MAP_W-1:0]          map_used;

    modport source (output valid, output point_x, output point_y_shifted,
                    output map_used, input ready);
    modport sink   (input valid, input point_x, input point_y_shifted,
                    input map_used, output ready);

endinterface

// ===== sv/fern_ifs_point_generator_top.sv =====
// ----------------------------------------------------------------------------
// fern_ifs_point_generator_top
// Barnsley fern point generator: picks one of four affine maps from a random
// choice word and applies it to the stored point, one point per word.
// ----------------------------------------------------------------------------
// The input stage registers an accepted choice word's map, the output stage
// its point word. One word per cycle while the output is not stalled; the
// point update (map, multiply, sum, saturate) feeds the point register directly.
// Reset (synchronous, active low): thresholds 1/80/90, point at origin,
// input and output stages empty.
module fern_ifs_point_generator_top import fern_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [THR_W-1:0]     i_cfg_data,
    fern_choice_if.sink          i_choice,
    fern_point_if.source         o_point
);

    t_thr                      r_thr;
    logic                      r_in_vld;
    t_map                      r_map;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic                      r_out_vld;
    logic signed [COORD_W-1:0] r_out_x, r_out_y;
    t_map                      r_out_map;

    t_map                      w_sel_map;
    logic signed [COORD_W-1:0] n_x, n_y, n_y_shift;
    logic                      w_fire;
    logic                      w_accept;

    // handshake control
    assign w_fire   = r_in_vld && (!r_out_vld || o_point.ready);
    assign i_choice.ready = !r_in_vld || w_fire;
    assign w_accept = i_choice.valid && i_choice.ready;

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.stem <= STEM_THR_RST;
            r_thr.main <= MAIN_THR_RST;
            r_thr.left <= LEFT_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEM: r_thr.stem <= i_cfg_data;
                CFG_MAIN: r_thr.main <= i_cfg_data;
                CFG_LEFT: r_thr.left <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // map selection on the incoming word
    fern_map_select u_map_select (
        .i_choice (i_choice.choice_value),
        .i_thr    (r_thr),
        .o_map    (w_sel_map)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_choice.ready) begin
            r_in_vld <= i_choice.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_map <= w_sel_map;
        end
    end

    // affine map datapath
    fern_point_update #(
        .FRAC_BITS (FRAC_BITS)
    ) u_point_update (
        .i_map     (r_map),
        .i_x       (r_x),
        .i_y       (r_y),
        .o_x       (n_x),
        .o_y       (n_y),
        .o_y_shift (n_y_shift)
    );

    // stored point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (w_fire) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_point.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_x   <= n_x;
            r_out_y   <= n_y_shift;
            r_out_map <= r_map;
        end
    end

    assign o_point.valid           = r_out_vld;
    assign o_point.point_x         = r_out_x;
    assign o_point.point_y_shifted = r_out_y;
    assign o_point.map_used        = r_out_map;

endmodule

// ===== sv/fern_map_select.sv =====
// ----------------------------------------------------------------------------
// fern_map_select
// Priority compare of the choice value against the three thresholds.
// ----------------------------------------------------------------------------
module fern_map_select import fern_pkg::*; (
    input  logic [CHOICE_W-1:0] i_choice,
    input  t_thr                i_thr,
    output t_map                o_map
);

    // stem first, then main leaf, then left, otherwise right
    always_comb begin
        if (i_choice < i_thr.stem) begin
            o_map = MAP_STEM;
        end else if (i_choice < i_thr.main) begin
            o_map = MAP_MAIN;
        end else if (i_choice < i_thr.left) begin
            o_map = MAP_LEFT;
        end else begin
            o_map = MAP_RIGHT;
        end
    end

endmodule

// ===== sv/fern_point_update.sv =====
// ----------------------------------------------------------------------------
// fern_point_update
// Applies the selected affine map to the current point: coefficient select,
// four products with floor truncation, sums and saturation.
// ----------------------------------------------------------------------------
module fern_point_update import fern_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  t_map                      i_map,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    output logic signed [COORD_W-1:0] o_x,
    output logic signed [COORD_W-1:0] o_y,
    output logic signed [COORD_W-1:0] o_y_shift
);

    // coefficient, product, truncated product and sum widths
    localparam int CW = FRAC_BITS + 3;
    localparam int PW = COORD_W + CW;
    localparam int TW = PW - FRAC_BITS;
    localparam int SW = TW + 2;
    localparam int YW = COORD_W + 2;

    localparam logic signed [CW-1:0] C_P85  = CW'(qc(85, FRAC_BITS));
    localparam logic signed [CW-1:0] C_P04  = CW'(qc(4, FRAC_BITS));
    localparam logic signed [CW-1:0] C_N04  = CW'(-qc(4, FRAC_BITS));
    localparam logic signed [CW-1:0] C_P16  = CW'(qc(16, FRAC_BITS));
    localparam logic signed [CW-1:0] C_P20  = CW'(qc(20, FRAC_BITS));
    localparam logic signed [CW-1:0] C_N26  = CW'(-qc(26, FRAC_BITS));
    localparam logic signed [CW-1:0] C_P23  = CW'(qc(23, FRAC_BITS));
    localparam logic signed [CW-1:0] C_P22  = CW'(qc(22, FRAC_BITS));
    localparam logic signed [CW-1:0] C_N15  = CW'(-qc(15, FRAC_BITS));
    localparam logic signed [CW-1:0] C_P28  = CW'(qc(28, FRAC_BITS));
    localparam logic signed [CW-1:0] C_P26  = CW'(qc(26, FRAC_BITS));
    localparam logic signed [CW-1:0] C_P24  = CW'(qc(24, FRAC_BITS));
    localparam logic signed [CW-1:0] C_P160 = CW'(qc(160, FRAC_BITS));
    localparam logic signed [CW-1:0] C_P44  = CW'(qc(44, FRAC_BITS));
    localparam logic signed [CW-1:0] C_ZERO = '0;

    localparam logic signed [SW-1:0] S_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] S_MIN = SW'(-64'sd2147483648);
    localparam logic signed [YW-1:0] Y_MAX = YW'(64'sd2147483647);
    localparam logic signed [YW-1:0] Y_MIN = YW'(-64'sd2147483648);
    localparam logic signed [YW-1:0] FIVE  = YW'(64'sd5 <<< FRAC_BITS);

    logic signed [CW-1:0] w_ca, w_cb, w_cc, w_cd, w_ce;
    logic signed [PW-1:0] w_pa, w_pb, w_pc, w_pd;
    logic signed [TW-1:0] w_ta, w_tb, w_tc, w_td;
    logic signed [SW-1:0] w_sx, w_sy;
    logic signed [YW-1:0] w_yd;

    // per-map coefficients: x->x, y->x, x->y, y->y, y offset
    always_comb begin
        case (i_map)
            MAP_STEM: begin
                w_ca = C_ZERO; w_cb = C_ZERO; w_cc = C_ZERO; w_cd = C_P16;
                w_ce = C_ZERO;
            end
            MAP_MAIN: begin
                w_ca = C_P85;  w_cb = C_P04;  w_cc = C_N04;  w_cd = C_P85;
                w_ce = C_P160;
            end
            MAP_LEFT: begin
                w_ca = C_P20;  w_cb = C_N26;  w_cc = C_P23;  w_cd = C_P22;
                w_ce = C_P160;
            end
            default: begin
                w_ca = C_N15;  w_cb = C_P28;  w_cc = C_P26;  w_cd = C_P24;
                w_ce = C_P44;
            end
        endcase
    end

    // full products, low fraction bits dropped (floor)
    assign w_pa = PW'(i_x) * PW'(w_ca);
    assign w_pb = PW'(i_y) * PW'(w_cb);
    assign w_pc = PW'(i_x) * PW'(w_cc);
    assign w_pd = PW'(i_y) * PW'(w_cd);

    assign w_ta = w_pa[PW-1:FRAC_BITS];
    assign w_tb = w_pb[PW-1:FRAC_BITS];
    assign w_tc = w_pc[PW-1:FRAC_BITS];
    assign w_td = w_pd[PW-1:FRAC_BITS];

    // exact sums
    assign w_sx = SW'(w_ta) + SW'(w_tb);
    assign w_sy = SW'(w_tc) + SW'(w_td) + SW'(w_ce);

    // saturate new coordinates to 32 bits
    always_comb begin
        if (w_sx > S_MAX) begin
            o_x = COORD_W'(S_MAX);
        end else if (w_sx < S_MIN) begin
            o_x = COORD_W'(S_MIN);
        end else begin
            o_x = w_sx[COORD_W-1:0];
        end

        if (w_sy > S_MAX) begin
            o_y = COORD_W'(S_MAX);
        end else if (w_sy < S_MIN) begin
            o_y = COORD_W'(S_MIN);
        end else begin
            o_y = w_sy[COORD_W-1:0];
        end
    end

    // y minus 5.0, saturated again
    assign w_yd = YW'(o_y) - FIVE;

    always_comb begin
        if (w_yd > Y_MAX) begin
            o_y_shift = COORD_W'(Y_MAX);
        end else if (w_yd < Y_MIN) begin
            o_y_shift = COORD_W'(Y_MIN);
        end else begin
            o_y_shift = w_yd[COORD_W-1:0];
        end
    end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fern point generator. A predictor of the four
// affine maps tracks the stored point and the threshold registers, and each
// point word is checked against the oldest predicted one. Directed map
// selection and threshold corner cases come first, then random choice words
// under several threshold settings, with random idling on both channels and
// a long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb;
    import fern_pkg::*;

    localparam int FRAC         = 16;
    localparam int HOLD_CYCLES  = 64;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE       = 4;

    // index past the end of the register list, ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y_shifted;
        t_map                      map;
    } t_point_word;

    // hundredths to fixed point, rounded to nearest
    function automatic longint coef(input int hundredths);
        return ((longint'(hundredths) << FRAC) + 64'sd50) / 100;
    endfunction

    localparam longint K_04  = coef(4);
    localparam longint K_15  = coef(15);
    localparam longint K_16  = coef(16);
    localparam longint K_20  = coef(20);
    localparam longint K_22  = coef(22);
    localparam longint K_23  = coef(23);
    localparam longint K_24  = coef(24);
    localparam longint K_26  = coef(26);
    localparam longint K_28  = coef(28);
    localparam longint K_44  = coef(44);
    localparam longint K_85  = coef(85);
    localparam longint K_160 = coef(160);
    localparam longint Y_OFFSET = longint'(5) << FRAC;

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [THR_W-1:0]     cfg_data;

    fern_choice_if choice_ch ();
    fern_point_if  point_ch ();

    fern_ifs_point_generator_top #(.FRAC_BITS(FRAC)) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_choice   (choice_ch),
        .o_point    (point_ch)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    t_thr                      thr;
    logic signed [COORD_W-1:0] fern_x;
    logic signed [COORD_W-1:0] fern_y;
    t_point_word               expected_points [$];

    int errors       = 0;
    int quiet_cycles = 0;
    bit sender_idle  = 1'b0;
    bit sink_idle    = 1'b0;
    bit hold_req     = 1'b0;

    // product with the low fraction bits dropped, rounds toward minus infinity
    function automatic longint trunc_mul(input longint a, input longint c);
        return (a * c) >>> FRAC;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[COORD_W-1:0];
    endfunction

    // pick the map, apply it to the stored point, return the point word
    function automatic t_point_word next_fern_point(input logic [CHOICE_W-1:0] choice);
        t_point_word w;
        longint      x;
        longint      y;
        longint      nx;
        longint      ny;
        x = fern_x;
        y = fern_y;
        if (choice < thr.stem) begin
            w.map = MAP_STEM;
            nx    = 0;
            ny    = trunc_mul(y, K_16);
        end else if (choice < thr.main) begin
            w.map = MAP_MAIN;
            nx    = trunc_mul(x, K_85) + trunc_mul(y, K_04);
            ny    = trunc_mul(x, -K_04) + trunc_mul(y, K_85) + K_160;
        end else if (choice < thr.left) begin
            w.map = MAP_LEFT;
            nx    = trunc_mul(x, K_20) + trunc_mul(y, -K_26);
            ny    = trunc_mul(x, K_23) + trunc_mul(y, K_22) + K_160;
        end else begin
            w.map = MAP_RIGHT;
            nx    = trunc_mul(x, -K_15) + trunc_mul(y, K_28);
            ny    = trunc_mul(x, K_26) + trunc_mul(y, K_24) + K_44;
        end
        fern_x      = clamp32(nx);
        fern_y      = clamp32(ny);
        w.x         = fern_x;
        w.y_shifted = clamp32(longint'(fern_y) - Y_OFFSET);
        return w;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [CHOICE_W-1:0] random_choice();
        if ($urandom_range(0, 7) == 0)
            return CHOICE_W'($urandom_range(100, 127));
        return CHOICE_W'($urandom_range(0, 99));
    endfunction

    // offer one choice word and record its point once accepted
    task automatic send_choice(input logic [CHOICE_W-1:0] choice);
        int gap;
        gap = 0;
        if (sender_idle && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap > 0) begin
            choice_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        choice_ch.valid        <= 1'b1;
        choice_ch.choice_value <= choice;
        @(posedge clk);
        while (!choice_ch.ready) @(posedge clk);
        expected_points.push_back(next_fern_point(choice));
    endtask

    // stop offering and wait for every predicted point to come out
    task automatic wait_drain();
        choice_ch.valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_STEM: thr.stem = val;
            CFG_MAIN: thr.main = val;
            CFG_LEFT: thr.left = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_thresholds(input logic [THR_W-1:0] s, input logic [THR_W-1:0] m,
                                   input logic [THR_W-1:0] l);
        wait_drain();
        write_reg(CFG_STEM, s);
        write_reg(CFG_MAIN, m);
        write_reg(CFG_LEFT, l);
    endtask

    // reset thresholds: each window edge plus choices past 99
    task automatic test_map_select();
        logic [CHOICE_W-1:0] picks [10] = '{7'd0, 7'd1, 7'd79, 7'd80, 7'd89,
                                            7'd90, 7'd99, 7'd100, 7'd127, 7'd42};
        sender_idle = 1'b0;
        sink_idle   = 1'b0;
        foreach (picks[i]) send_choice(picks[i]);
        wait_drain();
    endtask

    // all-zero, all-one and out-of-order thresholds, and the unused index
    task automatic test_threshold_corners();
        load_thresholds('0, '0, '0);
        send_choice(7'd0);
        send_choice(7'd127);
        load_thresholds('1, '1, '1);
        send_choice(7'd0);
        send_choice(7'd126);
        send_choice(7'd127);
        // main and left windows empty
        load_thresholds(7'd50, 7'd20, 7'd10);
        send_choice(7'd49);
        send_choice(7'd50);
        // main window empty, left window open
        load_thresholds(7'd10, 7'd5, 7'd60);
        send_choice(7'd7);
        send_choice(7'd30);
        wait_drain();
        write_reg(CFG_SPARE, '1);
        send_choice(7'd61);
        wait_drain();
    endtask

    // reset thresholds, long random runs with and without idling
    task automatic test_random_fern();
        load_thresholds(STEM_THR_RST, MAIN_THR_RST, LEFT_THR_RST);
        for (int chunk = 0; chunk < 7; chunk++) begin
            sender_idle = ($urandom_range(0, 3) != 0);
            sink_idle   = ($urandom_range(0, 3) != 0);
            repeat (100) send_choice(random_choice());
        end
        wait_drain();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        sender_idle = 1'b0;
        sink_idle   = 1'b0;
        hold_req    = 1'b1;
        repeat (40) send_choice(random_choice());
        wait_drain();
    endtask

    // several random threshold settings, sorted and arbitrary
    task automatic test_random_thresholds();
        logic [THR_W-1:0] t [$];
        for (int phase = 0; phase < 6; phase++) begin
            t = {};
            repeat (3) begin
                if (phase % 3 == 2)
                    t.push_back(THR_W'($urandom_range(0, 127)));
                else
                    t.push_back(THR_W'($urandom_range(0, 100)));
            end
            if (phase % 3 != 2)
                t.sort();
            load_thresholds(t[0], t[1], t[2]);
            sender_idle = (phase % 2 == 0);
            sink_idle   = (phase != 3);
            repeat (130) send_choice(CHOICE_W'($urandom_range(0, 127)));
        end
        wait_drain();
    endtask

    // receiver side: random stalls and the long hold-off
    initial begin : point_sink
        int gap;
        point_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                point_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                point_ch.ready <= 1'b1;
            end else if (sink_idle && $urandom_range(0, 3) == 0) begin
                gap = pick_gap();
                point_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                point_ch.ready <= 1'b1;
            end else begin
                point_ch.ready <= 1'b1;
            end
        end
    end

    // compare each point word with the oldest prediction
    always @(posedge clk) begin : point_check
        t_point_word want;
        if (rst_n && point_ch.valid && point_ch.ready) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected point word x=%0d y=%0d map=%0d", $time,
                         point_ch.point_x, point_ch.point_y_shifted, point_ch.map_used);
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (point_ch.point_x !== want.x) begin
                    $display("%0t: point_x expected %0d got %0d", $time,
                             want.x, point_ch.point_x);
                    errors++;
                end
                if (point_ch.point_y_shifted !== want.y_shifted) begin
                    $display("%0t: point_y_shifted expected %0d got %0d", $time,
                             want.y_shifted, point_ch.point_y_shifted);
                    errors++;
                end
                if (point_ch.map_used !== want.map) begin
                    $display("%0t: map_used expected %0d got %0d", $time,
                             want.map, point_ch.map_used);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk) begin : stall_watch
        if (!rst_n || (choice_ch.valid && choice_ch.ready) ||
            (point_ch.valid && point_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        thr    = {STEM_THR_RST, MAIN_THR_RST, LEFT_THR_RST};
        fern_x = '0;
        fern_y = '0;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_idx                <= CFG_STEM;
        cfg_data               <= '0;
        choice_ch.valid        <= 1'b0;
        choice_ch.choice_value <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_map_select();
        test_threshold_corners();
        test_random_fern();
        test_backpressure();
        test_random_thresholds();

        wait_drain();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && expected_points.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
